/* rtl/spi_pkg.sv */
// Package for the sounding profile interpolator: constants, opcodes, states.
// No dependencies.
`timescale 1ns / 1ps
package spi_pkg;
  localparam int unsigned MaxRowsDefault = 64;
  localparam int unsigned HW = 20;
  localparam int unsigned PW = 17;
  localparam int unsigned TW = 16;
  localparam int unsigned KelvinOffset = 27315;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_EQUAL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_UP,
    S_DIST,
    S_WALK_RD,
    S_WALK_CMP,
    S_FINAL_RD,
    S_SEC_LO,
    S_SEC_UP,
    S_FIELD,
    S_MUL,
    S_DIV,
    S_DONE,
    S_OUT
  } state_e;
endpackage

/* rtl/sounding_profile_interpolator.sv */
// Sounding profile interpolator top level: row table, sector walk, shared
// multiply and shift-subtract divider. Depends on spi_pkg.
`timescale 1ns / 1ps
//  channel | signals                                   | dir
//  in      | in_valid_i/in_ready_o, opcode_i, row_*_i, query_position_i | in
//  out     | out_valid_o/out_ready_i, pressure_pa_o, ..., status_o      | out
// Append and clear are done in the idle state. A query with no walk runs from its
// acceptance to the result handshake through the table reads and compares, three
// fields (multiply, NW+1 = 41 divide steps, sum each) and the output state.
// A walk adds a read and a compare per row and, unless it stops at a table end, a
// side pick; equal sector heights skip the fields and too few rows go straight to output.
// Reset clears state, row count and sector only; table memory is not cleared.
// in_ready_o is low while a query is worked on or its result waits.
module sounding_profile_interpolator import spi_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDefault,
  localparam int unsigned AW = $clog2(MAX_ROWS),
  localparam int unsigned CW = $clog2(MAX_ROWS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  input  logic [HW-1:0]        row_height_i,
  input  logic [PW-1:0]        row_pressure_i,
  input  logic signed [TW-1:0] row_temperature_i,
  input  logic signed [TW-1:0] row_dewpoint_i,
  input  logic [HW-1:0]        query_position_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PW-1:0]        pressure_pa_o,
  output logic [TW-1:0]        temperature_centikelvin_o,
  output logic [TW-1:0]        dewpoint_centikelvin_o,
  output logic [5:0]           sector_index_o,
  output logic [1:0]           status_o
);
  localparam int unsigned RW = HW + PW + 2 * TW;
  localparam int unsigned DW = HW + 2;   // signed height differences
  localparam int unsigned NW = DW + 18;  // signed products
  localparam int unsigned QC = $clog2(NW + 2);

  // table memory, one packed row per entry
  logic [RW-1:0] mem [MAX_ROWS];
  logic [AW-1:0] raddr;
  logic [RW-1:0] rdata_q;
  logic          we;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] lo_q, lo_d, up_q, up_d;
  logic [AW-1:0] near_q, near_d;
  logic [HW-1:0] qpos_q, qpos_d;
  logic [HW:0]   dist_q, dist_d, dl_q, dl_d;
  logic          dir_q, dir_d;   // 1: walking down
  logic [HW-1:0] hlo_q, hlo_d;
  logic [PW-1:0] plo_q, plo_d, pup_q, pup_d;
  logic signed [TW-1:0] tlo_q, tlo_d, tup_q, tup_d, dlo_q, dlo_d, dup_q, dup_d;
  logic signed [DW-1:0] den_q, den_d, pos_q, pos_d;
  logic [1:0]    fld_q, fld_d;
  logic [NW-1:0] num_q, num_d;    // magnitude
  logic          neg_q, neg_d;
  logic [NW:0]   rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [QC-1:0] bit_q, bit_d;
  logic [1:0]    st_q, st_d;
  logic [PW-1:0] o_p_q, o_p_d;
  logic [TW-1:0] o_t_q, o_t_d, o_d_q, o_d_d;
  logic [5:0]    o_s_q, o_s_d;

  logic [HW-1:0] rh;
  logic [PW-1:0] rpv;
  logic signed [TW-1:0] rtv, rdv;
  assign {rh, rpv, rtv, rdv} = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cnt_q[AW-1:0]] <= {row_height_i, row_pressure_i, row_temperature_i,
                             row_dewpoint_i};
    end
    rdata_q <= mem[raddr];
  end

  // shared distance unit
  logic [HW:0] dnow;
  logic signed [HW:0] dsub;
  assign dsub = $signed({1'b0, qpos_q}) - $signed({1'b0, rh});
  assign dnow = dsub[HW] ? (HW+1)'(-dsub) : (HW+1)'(dsub);

  // shared multiply, operand select
  logic signed [17:0] fdiff;
  logic signed [NW-1:0] prod;
  always_comb begin
    case (fld_q)
      2'd0:    fdiff = 18'($signed({1'b0, pup_q}) - $signed({1'b0, plo_q}));
      2'd1:    fdiff = 18'(tup_q) - 18'(tlo_q);
      default: fdiff = 18'(dup_q) - 18'(dlo_q);
    endcase
  end
  assign prod = NW'(fdiff) * NW'(pos_q);

  logic [DW-1:0] dmag;
  assign dmag = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
  logic [NW:0] trial;
  assign trial = {rem_q[NW-1:0], num_q[NW-1]} - (NW+1)'(dmag);

  // rounding result and saturation
  logic [NW-1:0] qr;
  logic signed [NW+1:0] val;
  logic [CW-1:0] last;
  assign last = cnt_q - CW'(1);

  function automatic logic [PW-1:0] satp(input logic signed [NW+1:0] v);
    if (v < 0) return '0;
    if (v > (NW+2)'(2**PW - 1)) return '1;
    return PW'(v);
  endfunction
  function automatic logic [TW-1:0] satt(input logic signed [NW+1:0] v);
    logic signed [NW+1:0] w;
    w = v + (NW+2)'(KelvinOffset);
    if (w < 0) return '0;
    if (w > (NW+2)'(2**TW - 1)) return '1;
    return TW'(w);
  endfunction

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; lo_d = lo_q; up_d = up_q; near_d = near_q;
    qpos_d = qpos_q; dist_d = dist_q; dl_d = dl_q; dir_d = dir_q;
    hlo_d = hlo_q; plo_d = plo_q; pup_d = pup_q; tlo_d = tlo_q; tup_d = tup_q;
    dlo_d = dlo_q; dup_d = dup_q; den_d = den_q; pos_d = pos_q; fld_d = fld_q;
    num_d = num_q; neg_d = neg_q; rem_d = rem_q; quo_d = quo_q; bit_d = bit_q;
    st_d = st_q;
    o_p_d = o_p_q; o_t_d = o_t_q; o_d_d = o_d_q; o_s_d = o_s_q;
    raddr = lo_q; we = 1'b0; in_ready_o = 1'b0; out_valid_o = 1'b0;
    qr = (quo_q + NW'(1)) >> 1;
    val = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (opcode_e'(opcode_i))
            OP_APPEND: if (cnt_q < CW'(MAX_ROWS)) begin
              we = 1'b1; cnt_d = cnt_q + CW'(1);
            end
            OP_CLEAR: begin cnt_d = '0; lo_d = '0; up_d = AW'(1); end
            OP_QUERY: begin
              qpos_d = query_position_i;
              if (cnt_q < CW'(2)) begin
                o_p_d = '0; o_t_d = '0; o_d_d = '0;
                o_s_d = 6'(lo_q); st_d = ST_FEW; state_d = S_OUT;
              end else state_d = S_RD_LO;
            end
            default: ;
          endcase
        end
      end
      S_RD_LO: begin                                         // rdata = h[lo]
        dl_d = dnow; raddr = up_q; state_d = S_RD_UP;
      end
      S_RD_UP: begin raddr = up_q; state_d = S_DIST; end     // rdata = h[up]
      S_DIST: begin
        if (dl_q == dnow) state_d = S_FINAL_RD;
        else if (dl_q < dnow) begin
          if (lo_q == '0) begin up_d = AW'(1); state_d = S_FINAL_RD; end
          else begin
            near_d = lo_q; dist_d = dl_q; dir_d = 1'b1; state_d = S_WALK_RD;
          end
        end else begin
          if (CW'(up_q) >= last) begin
            lo_d = AW'(cnt_q - CW'(2)); state_d = S_FINAL_RD;
          end else begin
            near_d = up_q; dist_d = dnow; dir_d = 1'b0; state_d = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        raddr = dir_q ? near_q - AW'(1) : near_q + AW'(1);
        state_d = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (dnow < dist_q) begin
          dist_d = dnow;
          if (dir_q) begin
            near_d = near_q - AW'(1);
            if (near_q == AW'(1)) begin
              lo_d = '0; up_d = AW'(1); state_d = S_FINAL_RD;
            end else state_d = S_WALK_RD;
          end else begin
            near_d = near_q + AW'(1);
            if (CW'(near_q) + CW'(1) >= last) begin
              lo_d = AW'(cnt_q - CW'(2)); up_d = AW'(last); state_d = S_FINAL_RD;
            end else state_d = S_WALK_RD;
          end
        end else begin
          raddr = near_q; state_d = S_SEC_LO; dir_d = 1'b1; // marks side pick
        end
      end
      S_FINAL_RD: begin raddr = lo_q; dir_d = 1'b0; state_d = S_SEC_LO; end
      S_SEC_LO: begin
        if (dir_q) begin
          // rdata = h[near]: choose side, then read lower row
          if (qpos_q >= rh) begin lo_d = near_q; up_d = near_q + AW'(1); end
          else begin lo_d = near_q - AW'(1); up_d = near_q; end
          dir_d = 1'b0; state_d = S_FINAL_RD;
        end else begin
          raddr = up_q;
          hlo_d = rh; plo_d = rpv; tlo_d = rtv; dlo_d = rdv;
          state_d = S_SEC_UP;
        end
      end
      S_SEC_UP: begin
        pup_d = rpv; tup_d = rtv; dup_d = rdv;
        den_d = DW'(rh) - DW'(hlo_q);
        pos_d = DW'(qpos_q) - DW'(hlo_q);
        fld_d = 2'd0; o_s_d = 6'(lo_q);
        if (rh == hlo_q) begin
          st_d = ST_EQUAL;
          o_p_d = plo_q; o_t_d = satt((NW+2)'(tlo_q)); o_d_d = satt((NW+2)'(dlo_q));
          state_d = S_OUT;
        end else begin st_d = ST_OK; state_d = S_MUL; end
      end
      S_MUL: begin
        neg_d = prod[NW-1] ^ den_q[DW-1];
        num_d = prod[NW-1] ? NW'(-prod) : NW'(prod);
        rem_d = '0; quo_d = '0; bit_d = QC'(NW); state_d = S_DIV;
      end
      S_DIV: begin
        // restoring division of 2n by d; quo = floor(2n/d), round = (quo+1)>>1
        if (!trial[NW]) begin rem_d = trial; quo_d = {quo_q[NW-2:0], 1'b1}; end
        else begin rem_d = {rem_q[NW-1:0], num_q[NW-1]}; quo_d = {quo_q[NW-2:0], 1'b0}; end
        num_d = {num_q[NW-2:0], 1'b0};
        bit_d = bit_q - QC'(1);
        if (bit_q == QC'(0)) state_d = S_DONE;
      end
      S_DONE: begin
        val = neg_q ? -(NW+2)'(qr) : (NW+2)'(qr);
        case (fld_q)
          2'd0: o_p_d = satp(val + (NW+2)'(plo_q));
          2'd1: o_t_d = satt(val + (NW+2)'(tlo_q));
          default: o_d_d = satt(val + (NW+2)'(dlo_q));
        endcase
        if (fld_q == 2'd2) state_d = S_OUT;
        else begin fld_d = fld_q + 2'd1; state_d = S_MUL; end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The divider iterates NW+1 times; num is shifted left with a trailing zero, so
  // that the dividend seen is 2*num.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; lo_q <= '0; up_q <= AW'(1);
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; lo_q <= lo_d; up_q <= up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    near_q <= near_d; qpos_q <= qpos_d; dist_q <= dist_d; dl_q <= dl_d;
    dir_q <= dir_d; hlo_q <= hlo_d; plo_q <= plo_d; pup_q <= pup_d;
    tlo_q <= tlo_d; tup_q <= tup_d; dlo_q <= dlo_d; dup_q <= dup_d;
    den_q <= den_d; pos_q <= pos_d; fld_q <= fld_d; neg_q <= neg_d;
    num_q <= (state_q == S_MUL) ? {num_d[NW-2:0], 1'b0} >> 1 : num_d;
    rem_q <= rem_d; quo_q <= quo_d; bit_q <= bit_d;
    st_q <= st_d;
    o_p_q <= o_p_d; o_t_q <= o_t_d; o_d_q <= o_d_d; o_s_q <= o_s_d;
  end

  assign pressure_pa_o = o_p_q;
  assign temperature_centikelvin_o = o_t_q;
  assign dewpoint_centikelvin_o = o_d_q;
  assign sector_index_o = o_s_q;
  assign status_o = st_q;
endmodule
